// ===== hdl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg: shared types for the trapezoid membership degree block
// Region codes, configuration register indexes and the side information
// that travels with each sample through the divider pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmd_pkg;

  // Region of the trapezoid that a sample falls into.
  typedef enum logic [1:0] {
    REGION_OUTSIDE = 2'd0,
    REGION_RISING  = 2'd1,
    REGION_PLATEAU = 2'd2,
    REGION_FALLING = 2'd3
  } region_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_EDGE_LOW      = 2'd0,
    CFG_PLATEAU_START = 2'd1,
    CFG_PLATEAU_END   = 2'd2,
    CFG_EDGE_HIGH     = 2'd3
  } cfg_index_t;

  // Side information that rides along with the divider data.
  typedef struct packed {
    logic    valid;
    region_t region;
  } div_tag_t;

endpackage

// ===== hdl/tmd_divider.sv =====
// ----------------------------------------------------------------------------
// tmd_divider: pipelined fractional restoring divider
// Computes floor((num << QUOT_BITS) / den) for num < den, one quotient bit
// per register stage, with a tag carried alongside each operand pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmd_divider #(
  parameter int DEN_WIDTH = 16,
  parameter int QUOT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DEN_WIDTH-1:0]  num,
  input  logic [DEN_WIDTH-1:0]  den,
  input  tmd_pkg::div_tag_t     tag_in,
  output logic [QUOT_BITS-1:0]  quot,
  output tmd_pkg::div_tag_t     tag_out
);
  import tmd_pkg::*;

  logic [DEN_WIDTH-1:0] rem_q [QUOT_BITS+1];
  logic [DEN_WIDTH-1:0] den_q [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo_q [QUOT_BITS+1];
  div_tag_t             tag_q [QUOT_BITS+1];

  assign rem_q[0] = num;
  assign den_q[0] = den;
  assign quo_q[0] = '0;
  assign tag_q[0] = tag_in;

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    logic [DEN_WIDTH:0] shifted;
    logic [DEN_WIDTH:0] trial;
    logic               bit_one;

    // The partial remainder stays below the divisor, so the difference
    // always fits back into DEN_WIDTH bits.
    assign shifted = {rem_q[k], 1'b0};
    assign trial   = shifted - {1'b0, den_q[k]};
    assign bit_one = (shifted >= {1'b0, den_q[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[k+1].valid <= 1'b0;
      end else begin
        tag_q[k+1].valid <= tag_q[k].valid;
      end
      tag_q[k+1].region <= tag_q[k].region;
      den_q[k+1]        <= den_q[k];
      rem_q[k+1]        <= bit_one ? trial[DEN_WIDTH-1:0] : shifted[DEN_WIDTH-1:0];
      if (QUOT_BITS > 1) begin
        quo_q[k+1] <= {quo_q[k][QUOT_BITS-2:0], bit_one};
      end else begin
        quo_q[k+1] <= QUOT_BITS'(bit_one);
      end
    end
  end

  assign quot    = quo_q[QUOT_BITS];
  assign tag_out = tag_q[QUOT_BITS];

endmodule

// ===== hdl/trapezoid_membership_degree.sv =====
// ----------------------------------------------------------------------------
// trapezoid_membership_degree: fuzzifier for one trapezoidal fuzzy set
// The strobe done follows start through the input register, the divider
//   stages and the output register; one sample per cycle while busy is low.
// The depth comes from the divider, which resolves one quotient bit per stage.
// Results cannot be held off by the receiver; each shows for one cycle.
// Reset (rst, synchronous) clears all breakpoints to zero and empties the
//   pipeline; busy is high during reset and the cycle after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoid_membership_degree #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // Sample transfer.
  input  logic                      start,
  output logic                      busy,
  input  logic [SAMPLE_WIDTH-1:0]   sample,
  // Configuration write port.
  input  logic                      wr_en,
  input  logic [1:0]                wr_index,
  input  logic [SAMPLE_WIDTH-1:0]   wr_data,
  // Result transfer.
  output logic                      done,
  output logic [FRACTION_BITS:0]    degree,
  output logic [1:0]                region
);
  import tmd_pkg::*;

  // Breakpoint registers, all signed on the sample's scale.
  logic signed [SAMPLE_WIDTH-1:0] edge_low;
  logic signed [SAMPLE_WIDTH-1:0] plateau_start;
  logic signed [SAMPLE_WIDTH-1:0] plateau_end;
  logic signed [SAMPLE_WIDTH-1:0] edge_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_low      <= '0;
      plateau_start <= '0;
      plateau_end   <= '0;
      edge_high     <= '0;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_EDGE_LOW:      edge_low      <= wr_data;
        CFG_PLATEAU_START: plateau_start <= wr_data;
        CFG_PLATEAU_END:   plateau_end   <= wr_data;
        CFG_EDGE_HIGH:     edge_high     <= wr_data;
        default: ;
      endcase
    end
  end

  // The block never refuses a sample except around reset.
  logic busy_hold;

  always_ff @(posedge clk) begin
    busy_hold <= rst;
  end

  assign busy = rst | busy_hold;

  logic accept;
  assign accept = start & ~busy;

  // First stage: classify the sample and form the numerator and divisor.
  // The region tests follow a fixed precedence: outside, then falling edge,
  // then rising edge, and the plateau last. On an edge the tests force
  // 0 <= numerator < divisor, so both fit in SAMPLE_WIDTH unsigned bits and
  // the quotient is always below 1.0; saturation never triggers.
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH:0]   fall_num;
  logic signed [SAMPLE_WIDTH:0]   fall_den;
  logic signed [SAMPLE_WIDTH:0]   rise_num;
  logic signed [SAMPLE_WIDTH:0]   rise_den;
  region_t                        region_next;
  logic [SAMPLE_WIDTH-1:0]        num_next;
  logic [SAMPLE_WIDTH-1:0]        den_next;

  assign x        = sample;
  assign fall_num = {edge_high[SAMPLE_WIDTH-1], edge_high} - {x[SAMPLE_WIDTH-1], x};
  assign fall_den = {edge_high[SAMPLE_WIDTH-1], edge_high}
                  - {plateau_end[SAMPLE_WIDTH-1], plateau_end};
  assign rise_num = {x[SAMPLE_WIDTH-1], x} - {edge_low[SAMPLE_WIDTH-1], edge_low};
  assign rise_den = {plateau_start[SAMPLE_WIDTH-1], plateau_start}
                  - {edge_low[SAMPLE_WIDTH-1], edge_low};

  always_comb begin
    // Outside and plateau samples divide zero by one, which gives zero; the
    // plateau's full degree is put in at the output.
    region_next = REGION_OUTSIDE;
    num_next    = '0;
    den_next    = SAMPLE_WIDTH'(1);
    if (x < edge_low || x > edge_high) begin
      region_next = REGION_OUTSIDE;
    end else if (x > plateau_end) begin
      region_next = REGION_FALLING;
      num_next    = fall_num[SAMPLE_WIDTH-1:0];
      den_next    = fall_den[SAMPLE_WIDTH-1:0];
    end else if (x < plateau_start) begin
      region_next = REGION_RISING;
      num_next    = rise_num[SAMPLE_WIDTH-1:0];
      den_next    = rise_den[SAMPLE_WIDTH-1:0];
    end else begin
      region_next = REGION_PLATEAU;
    end
  end

  logic [SAMPLE_WIDTH-1:0] num_s1;
  logic [SAMPLE_WIDTH-1:0] den_s1;
  div_tag_t                tag_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s1.valid <= 1'b0;
    end else begin
      tag_s1.valid <= accept;
    end
    tag_s1.region <= region_next;
    num_s1        <= num_next;
    den_s1        <= den_next;
  end

  // Divider pipeline: one quotient bit per stage.
  logic [FRACTION_BITS-1:0] quot_div;
  div_tag_t                 tag_div;

  tmd_divider #(
    .DEN_WIDTH (SAMPLE_WIDTH),
    .QUOT_BITS (FRACTION_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .num     (num_s1),
    .den     (den_s1),
    .tag_in  (tag_s1),
    .quot    (quot_div),
    .tag_out (tag_div)
  );

  // Output register: the plateau reports exactly 1.0, every other region
  // reports the quotient (zero outside the trapezoid).
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_div.valid;
    end
    region <= tag_div.region;
    if (tag_div.region == REGION_PLATEAU) begin
      degree <= {1'b1, {FRACTION_BITS{1'b0}}};
    end else begin
      degree <= {1'b0, quot_div};
    end
  end

endmodule

// ===== test/tb_trapezoid_membership_degree.sv =====
// ----------------------------------------------------------------------------
// tb_trapezoid_membership_degree: self-checking bench for the fuzzifier
// The bench drives samples through the start/busy handshake under several
// breakpoint settings. A scoreboard predicts the degree and region of each
// accepted sample and checks them, in order, against the done strobes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trapezoid_membership_degree;
  import tmd_pkg::*;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 16;

  // Full membership in Q1.FRACTION_BITS, and the signed range of one word.
  localparam longint ONE_Q    = longint'(1) << FRACTION_BITS;
  localparam longint WORD_MIN = -(longint'(1) << (SAMPLE_WIDTH - 1));
  localparam longint WORD_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;

  // The watchdog trips after this many cycles with no transfer on either side.
  // The longest quiet stretch of a correct run is a sender gap or the divider
  // latency, both far below this.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last result, to catch any stray strobe.
  localparam int DRAIN_CYCLES = FRACTION_BITS + 8;
  localparam int PHASES = 12;
  localparam int SAMPLES_PER_PHASE = 128;

  typedef logic [SAMPLE_WIDTH-1:0] word_t;
  typedef logic [FRACTION_BITS:0]  degree_t;

  typedef struct {
    degree_t degree;
    region_t region;
  } membership_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the four breakpoints, predicts the
  // membership of each accepted sample and checks results in arrival order.
  // --------------------------------------------------------------------------
  class membership_scoreboard;
    longint      breakpoint [4];
    membership_t expected [$];
    int          errors;

    function new();
      foreach (breakpoint[i]) breakpoint[i] = 0;
      errors = 0;
    endfunction

    function void set_breakpoint(cfg_index_t index, word_t value);
      breakpoint[index] = longint'($signed(value));
    endfunction

    // Truncating quotient on a sloping edge. A nonpositive operand gives zero;
    // a zero numerator comes up whenever the sample sits on a foot. The result
    // never exceeds full membership.
    function degree_t slope_degree(longint num, longint den);
      longint q;
      if (num <= 0 || den <= 0) return '0;
      q = (num << FRACTION_BITS) / den;
      if (q > ONE_Q) q = ONE_Q;
      return degree_t'(q);
    endfunction

    // Called once per accepted sample transfer.
    function void note_sample(word_t raw);
      longint      x;
      membership_t m;
      x = longint'($signed(raw));
      // The tests run in a fixed order of precedence: outside the feet first,
      // then the falling edge, then the rising edge, and the plateau last.
      if (x < breakpoint[CFG_EDGE_LOW] || x > breakpoint[CFG_EDGE_HIGH]) begin
        m.degree = '0;
        m.region = REGION_OUTSIDE;
      end else if (x > breakpoint[CFG_PLATEAU_END]) begin
        m.degree = slope_degree(breakpoint[CFG_EDGE_HIGH] - x,
                                breakpoint[CFG_EDGE_HIGH] - breakpoint[CFG_PLATEAU_END]);
        m.region = REGION_FALLING;
      end else if (x < breakpoint[CFG_PLATEAU_START]) begin
        m.degree = slope_degree(x - breakpoint[CFG_EDGE_LOW],
                                breakpoint[CFG_PLATEAU_START] - breakpoint[CFG_EDGE_LOW]);
        m.region = REGION_RISING;
      end else begin
        m.degree = degree_t'(ONE_Q);
        m.region = REGION_PLATEAU;
      end
      expected.push_back(m);
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // One line per mismatch, and every mismatch is counted.
    task report(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    // Called once per result transfer.
    task check_result(degree_t got_degree, region_t got_region);
      membership_t m;
      if (expected.size() == 0) begin
        report($sformatf("result with no sample pending (degree %0d, region %0d)",
                         got_degree, got_region));
        return;
      end
      m = expected.pop_front();
      if (got_degree !== m.degree)
        report($sformatf("degree %0d, predicted %0d", got_degree, m.degree));
      if (got_region !== m.region)
        report($sformatf("region %0d, predicted %0d", got_region, m.region));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block holds a known value from time zero.
  // --------------------------------------------------------------------------
  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       start    = 1'b0;
  word_t      sample   = '0;
  logic       wr_en    = 1'b0;
  logic [1:0] wr_index = CFG_EDGE_LOW;
  word_t      wr_data  = '0;
  logic       busy;
  logic       done;
  degree_t    degree;
  logic [1:0] region;

  membership_scoreboard sb = new();
  int quiet_cycles = 0;

  trapezoid_membership_degree #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .sample  (sample),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .done    (done),
    .degree  (degree),
    .region  (region)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side cannot stall, so every strobe seen at a rising edge is a
  // completed transfer. Outputs are read at the edge, before the block's own
  // nonblocking updates land, so the values are those of the ending cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(degree, region_t'(region));
  end

  // Watchdog: any transfer, in either direction, restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Clamp to the signed word range and take the low bits.
  function automatic word_t to_word(longint v);
    if (v < WORD_MIN) v = WORD_MIN;
    if (v > WORD_MAX) v = WORD_MAX;
    return word_t'(v);
  endfunction

  // Present one sample and hold it until the block takes it. Start is left
  // high so that a following sample goes out back to back; the caller lowers
  // it only together with a wait for a clock edge.
  task automatic send_sample(word_t value);
    start  <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(value);
  endtask

  // Sender gap: a geometric run of idle cycles, so that pct percent of the
  // cycles go idle on average and gaps of all lengths hit every pipeline stage.
  task automatic hold_off(int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every sample in flight has produced its
  // result. Each sample yields exactly one result, so an empty scoreboard
  // means an empty pipeline.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Program all four breakpoints, one write per cycle, and mirror each write
  // in the scoreboard once its edge has passed.
  task automatic write_breakpoints(longint low, longint rise_end, longint fall_start,
                                   longint high);
    cfg_index_t order [4];
    word_t      value [4];
    int         i;
    order = '{CFG_EDGE_LOW, CFG_PLATEAU_START, CFG_PLATEAU_END, CFG_EDGE_HIGH};
    value = '{to_word(low), to_word(rise_end), to_word(fall_start), to_word(high)};
    for (i = 0; i < 4; i++) begin
      wr_en    <= 1'b1;
      wr_index <= order[i];
      wr_data  <= value[i];
      @(posedge clk);
      sb.set_breakpoint(order[i], value[i]);
    end
    wr_en <= 1'b0;
  endtask

  task automatic send_list(longint values [$]);
    foreach (values[i]) send_sample(to_word(values[i]));
  endtask

  // Random breakpoints. Ordered sets dominate since they give real slopes;
  // the edge widths are sometimes tiny so that quotients with few steps and
  // exact breakpoint hits come up often.
  task automatic random_breakpoints(bit ordered, bit corners);
    longint corner [7];
    longint v [4];
    longint t;
    int     i;
    int     j;
    corner = '{WORD_MIN, WORD_MIN + 1, -1, 0, 1, WORD_MAX - 1, WORD_MAX};
    for (i = 0; i < 4; i++) begin
      if (corners) v[i] = corner[$urandom_range(6)];
      else v[i] = WORD_MIN + longint'($urandom_range(65535));
    end
    if (ordered) begin
      if (!corners) begin
        v[0] = WORD_MIN + longint'($urandom_range(65535));
        for (i = 1; i < 4; i++)
          v[i] = v[i-1] + longint'($urandom_range($urandom_range(1) ? 40 : 3000));
      end
      for (i = 1; i < 4; i++)
        for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
          t = v[j]; v[j] = v[j-1]; v[j-1] = t;
        end
    end
    write_breakpoints(v[0], v[1], v[2], v[3]);
  endtask

  // Random sample: a share of fully random words, so every bit toggles; half
  // spread over the trapezoid and a margin around it; the rest right on or
  // next to a breakpoint.
  function automatic word_t pick_sample();
    longint lo;
    longint hi;
    longint x;
    int     kind;
    lo = sb.breakpoint[0];
    hi = sb.breakpoint[0];
    foreach (sb.breakpoint[i]) begin
      if (sb.breakpoint[i] < lo) lo = sb.breakpoint[i];
      if (sb.breakpoint[i] > hi) hi = sb.breakpoint[i];
    end
    lo = lo - 3;
    hi = hi + 3;
    kind = $urandom_range(9);
    if (kind < 3) return word_t'($urandom);
    if (kind < 8) x = lo + longint'($urandom_range(int'(hi - lo)));
    else x = sb.breakpoint[$urandom_range(3)] + longint'($urandom_range(2)) - 1;
    return to_word(x);
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int pct_by_phase [3];
    int p;
    int n;
    // Phases rotate through a steady stream, a sparse sender and a lightly
    // gapped sender.
    pct_by_phase = '{0, 62, 14};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no gaps. With every breakpoint at zero, only zero itself
    // sits on the (single point) plateau; both word extremes fall outside.
    send_list('{WORD_MIN, WORD_MAX, 0, -1, 1});

    // A well-ordered trapezoid: each foot and one step either side, each plateau
    // end and one step outward; all regions and both zero-degree feet show up.
    wait_idle();
    write_breakpoints(-1000, -200, 300, 1500);
    send_list('{-1001, -1000, -999, -600, -201, -200, 0, 300, 301, 900,
                1499, 1500, 1501, WORD_MIN});

    // Breakpoints at the ends of the word range and around zero: each slope
    // spans nearly half of the word range.
    wait_idle();
    write_breakpoints(WORD_MIN, -1, 0, WORD_MAX);
    send_list('{WORD_MIN, -2, 0, 1, WORD_MAX - 1, WORD_MAX});

    // Random part. The first phases use fixed odd shapes, the rest random
    // breakpoints.
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        // Plateau end left of the left foot: the whole span counts as the
        // falling edge, and its quotient stays below full membership.
        0: write_breakpoints(0, 500, -50, 800);
        // Left foot beyond the right foot: every sample lands outside.
        1: write_breakpoints(500, 600, 700, -500);
        // Triangle: the plateau shrinks to one point.
        2: write_breakpoints(-3000, 100, 100, 4000);
        // Vertical edges: each foot coincides with its plateau end.
        3: write_breakpoints(-700, -700, 900, 900);
        7: random_breakpoints(1'b0, 1'b0);
        10: random_breakpoints(1'b0, 1'b1);
        11: random_breakpoints(1'b1, 1'b1);
        default: random_breakpoints(1'b1, 1'b0);
      endcase
      for (n = 0; n < SAMPLES_PER_PHASE; n++) begin
        send_sample(pick_sample());
        hold_off(pct_by_phase[p % 3]);
      end
    end

    // Let every result come back, then watch a while longer for stray strobes.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tmd_pkg.sv
hdl/tmd_divider.sv
hdl/trapezoid_membership_degree.sv
test/tb_trapezoid_membership_degree.sv
